// ===== hdl/ptq_pkg.sv =====
package ptq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 8;
  localparam logic [7:0] MAX_LEN_RESET = 8'd255;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    FN_ENQUEUE  = 3'd0,
    FN_PEEK     = 3'd1,
    FN_POP      = 3'd2,
    FN_CONTAINS = 3'd3,
    FN_CLEAR    = 3'd4,
    FN_STAT     = 3'd5
  } func_code_t;

  typedef enum logic [1:0] {
    STAT_DROPS    = 2'd0,
    STAT_REPLACED = 2'd1,
    STAT_ENQUEUED = 2'd2,
    STAT_PEAK     = 2'd3
  } stat_code_t;

  typedef enum logic [2:0] {
    MODE_REPL,
    MODE_WORST,
    MODE_BEST,
    MODE_FIND,
    MODE_POP
  } scan_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  src;
    logic [2:0]  pri;
    logic [7:0]  len;
    logic [15:0] payload;
    logic [31:0] tstamp;
    logic [31:0] seq;
  } entry_t;

endpackage

// ===== hdl/priority_tx_queue_with_eviction.sv =====
// Priority transmit queue with eviction.
// Input channel: in_valid / in_stall with func and the descriptor fields.
// Output channel: out_valid / out_stall, one result transfer per input transfer.
// Config: cfg_we writes cfg_data into the maximum frame length register;
// write only while the block is idle.
// Entries are held packed in arrival order in a memory with one read port and
// one write port that one sequencer walks with one shared compare unit,
// reading each entry visited and then evaluating it.
// Stat, clear and rejected operations go from dispatch straight to done;
// peek, contains and same-source search walk the held entries; pop and eviction
// then move each later entry down one place during compaction. A full-queue
// enqueue whose source search fails walks the queue again for the worst entry.
// One operation is in flight at a time; in_stall is high while it runs.
// The result sits in an output register; a new operation may start while it
// waits, but its own result holds in the sequencer until the register frees.
// Reset (synchronous, rst high) empties the queue, zeroes the counters, sets
// the next sequence number to 1 and the length limit to 255.
module priority_tx_queue_with_eviction #(
  parameter int QUEUE_DEPTH = ptq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [15:0] payload_ref,
  input  logic [7:0]  frame_length,
  input  logic [2:0]  frame_source,
  input  logic [2:0]  frame_priority,
  input  logic [31:0] arrival_time,
  input  logic        replace_same_source,
  input  logic [2:0]  pop_index,
  input  logic [1:0]  stat_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [2:0]  slot,
  output logic [2:0]  out_source,
  output logic [2:0]  out_priority,
  output logic [7:0]  out_length,
  output logic [15:0] out_payload_ref,
  output logic [31:0] out_time,
  output logic [31:0] out_sequence,
  output logic [3:0]  depth,
  output logic        queue_full,
  output logic [15:0] stat_value
);
  import ptq_pkg::*;

  localparam int IW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > 3) ? CW : 3;

  state_t state, state_next;
  scan_mode_t mode;

  logic [7:0]  max_len;
  logic [CW-1:0] held, idx, cand_idx, cand_idx_next, peak;
  logic [31:0] next_seq;
  logic [15:0] drop_cnt, repl_cnt, enq_cnt;

  logic [2:0]  q_func, q_src, q_pri, q_pop;
  logic [15:0] q_payload;
  logic [7:0]  q_len;
  logic [31:0] q_time;
  logic        q_repl;
  logic [1:0]  q_stat;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data, wr_data, cand, cand_next;
  logic [IW-1:0] rd_addr, wr_addr;
  logic mem_we;

  logic        r_ok;
  logic [2:0]  r_slot;
  entry_t      r_entry;
  logic [15:0] r_stat;
  logic [15:0] stat_sel;

  logic [CW-1:0] idx_inc;
  logic full, bad_len, pop_ok, last, match, out_load, take_rd;

  assign idx_inc = idx + 1'b1;
  assign full    = (held == CW'(QUEUE_DEPTH));
  assign bad_len = (q_len == 8'd0) || (q_len > max_len);
  assign pop_ok  = CMPW'(q_pop) < CMPW'(held);
  assign last    = (idx_inc == held);
  assign match   = (rd_data.src == q_src);
  assign out_load = !out_valid || !out_stall;

  always_comb begin
    case (q_stat)
      STAT_DROPS:    stat_sel = drop_cnt;
      STAT_REPLACED: stat_sel = repl_cnt;
      STAT_ENQUEUED: stat_sel = enq_cnt;
      default:       stat_sel = 16'(peak);
    endcase
  end

  // shared compare unit: worst or best candidate so far
  always_comb begin
    take_rd = 1'b0;
    if (idx == '0) begin
      take_rd = 1'b1;
    end else if (mode == MODE_WORST) begin
      take_rd = (rd_data.pri > cand.pri) ||
                ((rd_data.pri == cand.pri) && (rd_data.seq > cand.seq));
    end else begin
      take_rd = (rd_data.pri < cand.pri) ||
                ((rd_data.pri == cand.pri) && (rd_data.seq < cand.seq));
    end
    cand_next     = take_rd ? rd_data : cand;
    cand_idx_next = take_rd ? idx : cand_idx;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (q_func)
          FN_ENQUEUE: begin
            if (bad_len) state_next = ST_DONE;
            else if ((q_repl && held != '0) || full) state_next = ST_SCAN_RD;
            else state_next = ST_WRITE;
          end
          FN_PEEK, FN_CONTAINS: state_next = (held == '0) ? ST_DONE : ST_SCAN_RD;
          FN_POP: state_next = pop_ok ? ST_SCAN_RD : ST_DONE;
          default: state_next = ST_DONE;
        endcase
      end
      ST_SCAN_RD: state_next = ST_SCAN_EV;
      ST_SCAN_EV: begin
        case (mode)
          MODE_REPL: begin
            if (match) state_next = ST_DONE;
            else if (last) state_next = full ? ST_SCAN_RD : ST_WRITE;
            else state_next = ST_SCAN_RD;
          end
          MODE_WORST: begin
            if (last) state_next = (q_pri < cand_next.pri) ? ST_SHIFT_RD : ST_DONE;
            else state_next = ST_SCAN_RD;
          end
          MODE_BEST: state_next = last ? ST_DONE : ST_SCAN_RD;
          MODE_FIND: state_next = (match || last) ? ST_DONE : ST_SCAN_RD;
          MODE_POP: state_next = ST_SHIFT_RD;
          default: state_next = ST_DONE;
        endcase
      end
      ST_SHIFT_RD: begin
        if (idx_inc >= held) state_next = (mode == MODE_WORST) ? ST_WRITE : ST_DONE;
        else state_next = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: state_next = ST_SHIFT_RD;
      ST_WRITE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    rd_addr  = (state == ST_SHIFT_RD) ? idx_inc[IW-1:0] : idx[IW-1:0];
    mem_we   = 1'b0;
    wr_addr  = idx[IW-1:0];
    wr_data  = rd_data;
    case (state)
      ST_SCAN_EV: begin
        if (mode == MODE_REPL && match) begin
          mem_we  = 1'b1;
          wr_data = '{src: rd_data.src, pri: q_pri, len: q_len, payload: q_payload,
                      tstamp: q_time, seq: rd_data.seq};
        end
      end
      ST_SHIFT_WR: mem_we = 1'b1;
      ST_WRITE: begin
        mem_we  = 1'b1;
        wr_addr = held[IW-1:0];
        wr_data = '{src: q_src, pri: q_pri, len: q_len, payload: q_payload,
                    tstamp: q_time, seq: next_seq};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= MODE_FIND;
      held      <= '0;
      peak      <= '0;
      next_seq  <= 32'd1;
      drop_cnt  <= '0;
      repl_cnt  <= '0;
      enq_cnt   <= '0;
      max_len   <= MAX_LEN_RESET;
      out_valid <= 1'b0;
      idx       <= '0;
      cand_idx  <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) max_len <= cfg_data;

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            q_func    <= func;
            q_payload <= payload_ref;
            q_len     <= frame_length;
            q_src     <= frame_source;
            q_pri     <= frame_priority;
            q_time    <= arrival_time;
            q_repl    <= replace_same_source;
            q_pop     <= pop_index;
            q_stat    <= stat_select;
          end
        end
        ST_DISPATCH: begin
          r_ok    <= (q_func == FN_CLEAR) || (q_func == FN_STAT);
          r_slot  <= '0;
          r_entry <= '0;
          r_stat  <= (q_func == FN_STAT) ? stat_sel : 16'd0;
          idx     <= (q_func == FN_POP) ? CW'(q_pop) : '0;
          case (q_func)
            FN_ENQUEUE: begin
              if (bad_len && drop_cnt != CNT_MAX) drop_cnt <= drop_cnt + 1'b1;
              mode <= (q_repl && held != '0) ? MODE_REPL : MODE_WORST;
            end
            FN_PEEK: mode <= MODE_BEST;
            FN_CONTAINS: mode <= MODE_FIND;
            FN_POP: mode <= MODE_POP;
            FN_CLEAR: begin
              held     <= '0;
              peak     <= '0;
              next_seq <= 32'd1;
              drop_cnt <= '0;
              repl_cnt <= '0;
              enq_cnt  <= '0;
            end
            default: ;
          endcase
        end
        ST_SCAN_EV: begin
          cand     <= cand_next;
          cand_idx <= cand_idx_next;
          case (mode)
            MODE_REPL: begin
              if (match) begin
                r_ok    <= 1'b1;
                r_slot  <= 3'(idx);
                r_entry <= wr_data;
                if (repl_cnt != CNT_MAX) repl_cnt <= repl_cnt + 1'b1;
              end else if (last && full) begin
                mode <= MODE_WORST;
                idx  <= '0;
              end else begin
                idx <= idx_inc;
              end
            end
            MODE_WORST: begin
              if (last) begin
                // evicted or rejected, a drop either way
                if (drop_cnt != CNT_MAX) drop_cnt <= drop_cnt + 1'b1;
                idx <= cand_idx_next;
              end else begin
                idx <= idx_inc;
              end
            end
            MODE_BEST: begin
              idx <= idx_inc;
              if (last) begin
                r_ok    <= 1'b1;
                r_slot  <= 3'(cand_idx_next);
                r_entry <= cand_next;
              end
            end
            MODE_FIND: begin
              idx <= idx_inc;
              if (match) r_ok <= 1'b1;
            end
            MODE_POP: begin
              r_ok    <= 1'b1;
              r_slot  <= 3'(idx);
              r_entry <= rd_data;
            end
            default: ;
          endcase
        end
        ST_SHIFT_RD: begin
          if (idx_inc >= held) held <= held - 1'b1;
        end
        ST_SHIFT_WR: idx <= idx_inc;
        ST_WRITE: begin
          held     <= held + 1'b1;
          next_seq <= next_seq + 1'b1;
          if (enq_cnt != CNT_MAX) enq_cnt <= enq_cnt + 1'b1;
          if (held + 1'b1 > peak) peak <= held + 1'b1;
          r_ok    <= 1'b1;
          r_slot  <= 3'(held);
          r_entry <= wr_data;
        end
        default: ;
      endcase

      if (state == ST_DONE && out_load) begin
        out_valid       <= 1'b1;
        ok              <= r_ok;
        slot            <= r_slot;
        out_source      <= r_entry.src;
        out_priority    <= r_entry.pri;
        out_length      <= r_entry.len;
        out_payload_ref <= r_entry.payload;
        out_time        <= r_entry.tstamp;
        out_sequence    <= r_entry.seq;
        depth           <= 4'(held);
        queue_full      <= full;
        stat_value      <= r_stat;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ptq_pkg::*;

  localparam int CAP = 8;

  typedef struct {
    logic [2:0]  fn;
    logic [15:0] pref;
    logic [7:0]  len;
    logic [2:0]  src;
    logic [2:0]  pri;
    logic [31:0] tm;
    logic        repl;
    logic [2:0]  pidx;
    logic [1:0]  ssel;
  } request_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  slot;
    logic [2:0]  src;
    logic [2:0]  pri;
    logic [7:0]  len;
    logic [15:0] pref;
    logic [31:0] tm;
    logic [31:0] seq;
    logic [3:0]  depth;
    logic        full;
    logic [15:0] stat;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [7:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] func = 0;
  logic [15:0] payload_ref = 0;
  logic [7:0] frame_length = 0;
  logic [2:0] frame_source = 0;
  logic [2:0] frame_priority = 0;
  logic [31:0] arrival_time = 0;
  logic replace_same_source = 0;
  logic [2:0] pop_index = 0;
  logic [1:0] stat_select = 0;
  logic out_valid;
  logic out_stall = 0;
  logic ok;
  logic [2:0] slot, out_source, out_priority;
  logic [7:0] out_length;
  logic [15:0] out_payload_ref;
  logic [31:0] out_time, out_sequence;
  logic [3:0] depth;
  logic queue_full;
  logic [15:0] stat_value;

  priority_tx_queue_with_eviction uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .payload_ref(payload_ref), .frame_length(frame_length),
    .frame_source(frame_source), .frame_priority(frame_priority),
    .arrival_time(arrival_time), .replace_same_source(replace_same_source),
    .pop_index(pop_index), .stat_select(stat_select),
    .out_valid(out_valid), .out_stall(out_stall), .ok(ok), .slot(slot),
    .out_source(out_source), .out_priority(out_priority),
    .out_length(out_length), .out_payload_ref(out_payload_ref),
    .out_time(out_time), .out_sequence(out_sequence), .depth(depth),
    .queue_full(queue_full), .stat_value(stat_value)
  );

  always #5 clk = ~clk;

  // queue shadow
  logic [7:0]  max_len;
  entry_t      q_entry [CAP];
  int          q_held;
  logic [31:0] q_next_seq;
  logic [15:0] n_drops, n_replaced, n_enqueued;
  int          q_peak;

  answer_t pending_answers[$];
  int      mismatches = 0;
  bit      hold_off = 0;
  int      burst_left = 0;

  function automatic void bump(inout logic [15:0] c);
    if (c != CNT_MAX) c++;
  endfunction

  function automatic void clear_queue();
    for (int i = 0; i < CAP; i++) q_entry[i] = '0;
    q_held = 0;
    q_next_seq = 1;
    n_drops = 0;
    n_replaced = 0;
    n_enqueued = 0;
    q_peak = 0;
  endfunction

  function automatic void report(inout answer_t a, input int i);
    a.slot = 3'(i);
    a.src = q_entry[i].src;
    a.pri = q_entry[i].pri;
    a.len = q_entry[i].len;
    a.pref = q_entry[i].payload;
    a.tm = q_entry[i].tstamp;
    a.seq = q_entry[i].seq;
  endfunction

  function automatic void remove_entry(int pos);
    for (int i = pos; i + 1 < q_held; i++) q_entry[i] = q_entry[i + 1];
    q_held--;
    q_entry[q_held] = '0;
  endfunction

  function automatic answer_t predict_queue(request_t r);
    answer_t a;
    int w, b;
    bit done;
    a = '0;
    done = 0;
    case (r.fn)
      FN_ENQUEUE: begin
        if (r.len == 0 || r.len > max_len) begin
          bump(n_drops);
          done = 1;
        end
        if (!done && r.repl) begin
          for (int i = 0; i < q_held && !done; i++) begin
            if (q_entry[i].src == r.src) begin
              q_entry[i].len = r.len;
              q_entry[i].pri = r.pri;
              q_entry[i].payload = r.pref;
              q_entry[i].tstamp = r.tm;
              bump(n_replaced);
              report(a, i);
              a.ok = 1;
              done = 1;
            end
          end
        end
        if (!done && q_held >= CAP) begin
          w = 0;
          for (int i = 1; i < q_held; i++)
            if (q_entry[i].pri > q_entry[w].pri ||
                (q_entry[i].pri == q_entry[w].pri && q_entry[i].seq > q_entry[w].seq))
              w = i;
          if (r.pri >= q_entry[w].pri) done = 1;
          else remove_entry(w);
          bump(n_drops);
        end
        if (!done) begin
          q_entry[q_held] = '{src: r.src, pri: r.pri, len: r.len, payload: r.pref,
                              tstamp: r.tm, seq: q_next_seq};
          q_next_seq++;
          q_held++;
          bump(n_enqueued);
          if (q_held > q_peak) q_peak = q_held;
          report(a, q_held - 1);
          a.ok = 1;
        end
      end
      FN_PEEK: if (q_held > 0) begin
        b = 0;
        for (int i = 1; i < q_held; i++)
          if (q_entry[i].pri < q_entry[b].pri ||
              (q_entry[i].pri == q_entry[b].pri && q_entry[i].seq < q_entry[b].seq))
            b = i;
        report(a, b);
        a.ok = 1;
      end
      FN_POP: if (r.pidx < q_held) begin
        report(a, r.pidx);
        remove_entry(r.pidx);
        a.ok = 1;
      end
      FN_CONTAINS:
        for (int i = 0; i < q_held; i++) if (q_entry[i].src == r.src) a.ok = 1;
      FN_CLEAR: begin
        clear_queue();
        a.ok = 1;
      end
      FN_STAT: begin
        case (r.ssel)
          STAT_DROPS:    a.stat = n_drops;
          STAT_REPLACED: a.stat = n_replaced;
          STAT_ENQUEUED: a.stat = n_enqueued;
          default:       a.stat = 16'(q_peak);
        endcase
        a.ok = 1;
      end
      default: ;
    endcase
    a.depth = 4'(q_held);
    a.full = (q_held == CAP);
    return a;
  endfunction

  // receiver stall pattern, overridden by a long hold-off
  always @(posedge clk) begin
    out_stall <= hold_off || (($urandom_range(0, 7) < 3) && ($urandom_range(0, 3) != 0));
  end

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{ok, slot, out_source, out_priority, out_length, out_payload_ref,
              out_time, out_sequence, depth, queue_full, stat_value};
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // drive one transfer and hold it until accepted; valid stays up afterwards
  // until the next transfer, a gap or a drain takes it down
  task automatic send(request_t r, bit gaps = 1);
    int gap;
    if (gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_valid <= 1;
    func <= r.fn;
    payload_ref <= r.pref;
    frame_length <= r.len;
    frame_source <= r.src;
    frame_priority <= r.pri;
    arrival_time <= r.tm;
    replace_same_source <= r.repl;
    pop_index <= r.pidx;
    stat_select <= r.ssel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_answers.push_back(predict_queue(r));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_max_len(logic [7:0] v);
    drain();
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    max_len = v;
  endtask

  function automatic request_t rand_frame(int len_hi);
    request_t r;
    r.fn = FN_ENQUEUE;
    r.pref = 16'($urandom);
    r.len = 8'($urandom_range(1, len_hi));
    r.src = 3'($urandom_range(0, 7));
    r.pri = 3'($urandom_range(0, 7));
    r.tm = $urandom;
    r.repl = 1'($urandom_range(0, 1));
    r.pidx = 3'($urandom_range(0, 7));
    r.ssel = 2'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic request_t op(logic [2:0] fn, logic [2:0] arg = 0);
    request_t r;
    r = rand_frame(255);
    r.fn = fn;
    r.src = arg;
    r.pidx = arg;
    r.ssel = arg[1:0];
    return r;
  endfunction

  task automatic test_directed();
    request_t r;
    send(op(FN_PEEK));
    send(op(FN_POP, 0));
    r = rand_frame(255); r.len = 0; send(r);
    r = rand_frame(255); r.len = 255; r.pref = 16'hFFFF; r.tm = '1;
    r.src = 7; r.pri = 7; r.repl = 0; send(r);
    r = rand_frame(255); r.len = 1; r.pref = 0; r.tm = 0; r.src = 0; r.pri = 0;
    r.repl = 0; send(r);
    r = rand_frame(255); r.src = 7; r.pri = 3; r.repl = 1; send(r);
    for (int i = 0; i < 7; i++) begin
      r = rand_frame(255); r.repl = 0; r.pri = 4; send(r);
    end
    r = rand_frame(255); r.repl = 0; r.pri = 7; send(r);
    r = rand_frame(255); r.repl = 0; r.pri = 2; send(r);
    send(op(FN_PEEK));
    send(op(FN_CONTAINS, 0));
    send(op(FN_POP, 7));
    send(op(FN_POP, 7));
    for (int s = 0; s < 4; s++) send(op(FN_STAT, 3'(s)));
    send(op(3'd6));
    send(op(3'd7));
    send(op(FN_CLEAR));
  endtask

  task automatic test_length_limit();
    request_t r;
    write_max_len(1);
    for (int i = 0; i < 6; i++) begin
      r = rand_frame(3); send(r);
    end
    write_max_len(100);
    for (int i = 0; i < 10; i++) begin
      r = rand_frame(255); send(r);
    end
    send(op(FN_STAT, 3'(STAT_DROPS)));
    write_max_len(255);
  endtask

  function automatic request_t rand_op();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return rand_frame($urandom_range(0, 3) == 0 ? 255 : max_len);
    if (k < 62) return op(FN_PEEK);
    if (k < 74) return op(FN_POP, 3'($urandom_range(0, 7)));
    if (k < 82) return op(FN_CONTAINS, 3'($urandom_range(0, 7)));
    if (k < 92) return op(FN_STAT, 3'($urandom_range(0, 3)));
    if (k < 96) return op(FN_CLEAR);
    return op(3'($urandom_range(6, 7)));
  endfunction

  task automatic test_random();
    for (int p = 0; p < 9; p++) begin
      if (p % 3 == 2) write_max_len(8'($urandom_range(1, 255)));
      for (int i = 0; i < 90; i++) send(rand_op(), p % 4 != 1);
    end
  endtask

  // hold the receiver off while the sender keeps offering transfers
  task automatic test_backpressure();
    request_t r;
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++) begin
        r = rand_frame(max_len); send(r, 0);
      end
    join
    drain();
    for (int i = 0; i < 10; i++) send(rand_op());
    drain();
  endtask

  initial begin
    max_len = MAX_LEN_RESET;
    clear_queue();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_length_limit();
    test_backpressure();
    test_random();
    write_max_len(255);
    for (int i = 0; i < 80; i++) send(rand_op());
    drain();
    if (mismatches == 0 && pending_answers.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #3ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ptq_pkg.sv
hdl/priority_tx_queue_with_eviction.sv
test/testbench.sv
